@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

`endif

@@ sv/bft_pkg.sv @@
package bft_pkg;

  typedef enum logic [3:0] {
    KIND_OPEN  = 4'd0,
    KIND_CLOSE = 4'd1,
    KIND_COMMA = 4'd2,
    KIND_COLON = 4'd3,
    KIND_IDENT = 4'd4,
    KIND_CC    = 4'd5,
    KIND_PROJ  = 4'd6,
    KIND_LIB   = 4'd7,
    KIND_FILES = 4'd8,
    KIND_FLAGS = 4'd9,
    KIND_ERROR = 4'd10,
    KIND_END   = 4'd11
  } token_kind_e;

  typedef enum logic [2:0] {
    BC_BLANK,
    BC_OPEN,
    BC_CLOSE,
    BC_COMMA,
    BC_COLON,
    BC_WORD,
    BC_END,
    BC_OTHER
  } byte_class_e;

  localparam int LEN_BITS = 8;
  localparam int POS_OUT_BITS = 16;
  localparam int NUM_KW = 5;
  localparam int KW_MAX_LEN = 5;

  localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_END   = 8'h00;

  // Keyword spellings, zero padded; a word byte is never zero, so padding never matches.
  localparam logic [7:0] KW_CHAR [NUM_KW][KW_MAX_LEN] = '{
    '{"C", "C", 8'h00, 8'h00, 8'h00},
    '{"P", "R", "O", "J", 8'h00},
    '{"L", "I", "B", 8'h00, 8'h00},
    '{"F", "I", "L", "E", "S"},
    '{"F", "L", "A", "G", "S"}
  };
  localparam logic [LEN_BITS-1:0] KW_LEN [NUM_KW] = '{8'd2, 8'd4, 8'd3, 8'd5, 8'd5};
  localparam token_kind_e KW_KIND [NUM_KW] = '{KIND_CC, KIND_PROJ, KIND_LIB, KIND_FILES,
                                               KIND_FLAGS};

  localparam int RES_DEPTH = 4;
  localparam int PTR_BITS = $clog2(RES_DEPTH);
  localparam int LVL_BITS = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    token_kind_e                token_kind;
    logic [POS_OUT_BITS-1:0]    start_offset;
    logic [LEN_BITS-1:0]        token_length;
    logic                       last_of_run;
  } token_t;

  // Up to two results produced by one byte.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  function automatic byte_class_e classify(input logic [7:0] b);
    byte_class_e c;
    if (b == CH_END) c = BC_END;
    else if (b == CH_SPACE || (b >= 8'd9 && b <= 8'd13)) c = BC_BLANK;
    else if (b == CH_OPEN) c = BC_OPEN;
    else if (b == CH_CLOSE) c = BC_CLOSE;
    else if (b == CH_COMMA) c = BC_COMMA;
    else if (b == CH_COLON) c = BC_COLON;
    else if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
             (b >= "a" && b <= "z") || b == CH_DOT) c = BC_WORD;
    else c = BC_OTHER;
    return c;
  endfunction

  function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] cand,
                                               input logic [LEN_BITS-1:0] idx,
                                               input logic [7:0] b);
    logic [NUM_KW-1:0] r;
    r = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (cand[k] && idx == LEN_BITS'(j) && KW_CHAR[k][j] == b) r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic token_kind_e word_kind(input logic [NUM_KW-1:0] cand,
                                            input logic [LEN_BITS-1:0] len);
    token_kind_e kd;
    kd = KIND_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k] && len == KW_LEN[k]) kd = KW_KIND[k];
    end
    return kd;
  endfunction

endpackage

@@ sv/bft_if.sv @@
interface bft_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface bft_token_if;
  import bft_pkg::*;
  logic                    valid;
  logic                    ready;
  token_kind_e             token_kind;
  logic [POS_OUT_BITS-1:0] start_offset;
  logic [LEN_BITS-1:0]     token_length;
  logic                    last_of_run;

  modport source (output valid, output token_kind, output start_offset, output token_length,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input start_offset, input token_length,
                input last_of_run, output ready);
endinterface

@@ sv/bft_result_fifo.sv @@
module bft_result_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bft_pkg::push_t            push_i,
  output logic                      room_o,
  output logic [bft_pkg::LVL_BITS-1:0] level_o,
  bft_token_if.source               out_o
);
  import bft_pkg::*;

  token_t                mem_q [RES_DEPTH];
  logic [PTR_BITS-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [LVL_BITS-1:0]   level_q, level_d;
  logic                  pop;
  token_t                head;

  assign pop     = (level_q != '0) && out_o.ready;
  assign room_o  = level_q <= LVL_BITS'(RES_DEPTH - 2);
  assign level_o = level_q;

  always_comb begin
    wr_d    = wr_q + PTR_BITS'(push_i.count);
    rd_d    = rd_q + PTR_BITS'(pop);
    level_d = level_q + LVL_BITS'(push_i.count) - LVL_BITS'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_q + PTR_BITS'(1)] <= push_i.second;
  end

  assign head              = mem_q[rd_q];
  assign out_o.valid        = level_q != '0;
  assign out_o.token_kind   = head.token_kind;
  assign out_o.start_offset = head.start_offset;
  assign out_o.token_length = head.token_length;
  assign out_o.last_of_run  = head.last_of_run;
endmodule

@@ sv/bft_core.sv @@
module bft_core #(
  parameter int MAX_LEXEME  = 256,
  parameter int OFFSET_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bft_byte_if.sink       in_i,
  input  logic           room_i,
  output bft_pkg::push_t push_o
);
  import bft_pkg::*;

  // input register
  logic       stg_v_q, stg_v_d;
  logic [7:0] stg_b_q, stg_b_d;
  logic       fire;

  // scanner state
  logic                   in_word_q, in_word_d;
  logic [LEN_BITS-1:0]    wlen_q, wlen_d;
  logic [OFFSET_BITS-1:0] wstart_q, wstart_d;
  logic [NUM_KW-1:0]      cand_q, cand_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic                   failed_q, failed_d;

  byte_class_e            cls;
  logic [31:0]            pos_ext, wstart_ext;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   word_out, byte_out, too_long;
  token_t                 word_tok, byte_tok;
  push_t                  push;

  assign fire      = stg_v_q && room_i;
  assign in_i.ready = !stg_v_q || room_i;

  always_comb begin
    stg_v_d = stg_v_q;
    stg_b_d = stg_b_q;
    if (in_i.valid && in_i.ready) begin
      stg_v_d = 1'b1;
      stg_b_d = in_i.text_byte;
    end else if (fire) begin
      stg_v_d = 1'b0;
    end
  end

  assign cls        = classify(stg_b_q);
  assign pos_ext    = 32'(pos_q);
  assign wstart_ext = 32'(wstart_q);
  assign pos_inc    = pos_q + OFFSET_BITS'(1);
  assign too_long   = ({1'b0, wlen_q} + 9'd1) >= 9'(MAX_LEXEME);

  always_comb begin
    in_word_d = in_word_q;
    wlen_d    = wlen_q;
    wstart_d  = wstart_q;
    cand_d    = cand_q;
    pos_d     = pos_q;
    failed_d  = failed_q;
    word_out  = 1'b0;
    byte_out  = 1'b0;

    word_tok.token_kind   = word_kind(cand_q, wlen_q);
    word_tok.start_offset = wstart_ext[POS_OUT_BITS-1:0];
    word_tok.token_length = wlen_q;
    word_tok.last_of_run  = 1'b0;

    byte_tok.token_kind   = KIND_ERROR;
    byte_tok.start_offset = pos_ext[POS_OUT_BITS-1:0];
    byte_tok.token_length = LEN_BITS'(1);
    byte_tok.last_of_run  = 1'b1;

    if (failed_q) begin
      // drop bytes until end of text
      if (cls == BC_END) begin
        in_word_d = 1'b0;
        wlen_d    = '0;
        wstart_d  = '0;
        cand_d    = '1;
        pos_d     = '0;
        failed_d  = 1'b0;
      end else begin
        pos_d = pos_inc;
      end
    end else if (in_word_q && cls == BC_WORD) begin
      if (too_long) begin
        byte_out  = 1'b1;
        failed_d  = 1'b1;
        in_word_d = 1'b0;
      end else begin
        cand_d = narrow(cand_q, wlen_q, stg_b_q);
        wlen_d = wlen_q + LEN_BITS'(1);
      end
      pos_d = pos_inc;
    end else begin
      if (in_word_q) begin
        word_out  = 1'b1;
        in_word_d = 1'b0;
        wlen_d    = '0;
        cand_d    = '1;
      end
      pos_d = pos_inc;
      unique case (cls)
        BC_END: begin
          byte_out              = 1'b1;
          byte_tok.token_kind   = KIND_END;
          byte_tok.token_length = '0;
          in_word_d = 1'b0;
          wlen_d    = '0;
          wstart_d  = '0;
          cand_d    = '1;
          pos_d     = '0;
          failed_d  = 1'b0;
        end
        BC_BLANK: ;
        BC_OPEN: begin
          byte_out            = 1'b1;
          byte_tok.token_kind = KIND_OPEN;
        end
        BC_CLOSE: begin
          byte_out            = 1'b1;
          byte_tok.token_kind = KIND_CLOSE;
        end
        BC_COMMA: begin
          byte_out            = 1'b1;
          byte_tok.token_kind = KIND_COMMA;
        end
        BC_COLON: begin
          byte_out            = 1'b1;
          byte_tok.token_kind = KIND_COLON;
        end
        BC_WORD: begin
          in_word_d = 1'b1;
          wstart_d  = pos_q;
          wlen_d    = LEN_BITS'(1);
          cand_d    = narrow('1, '0, stg_b_q);
        end
        default: begin
          byte_out = 1'b1;
          failed_d = 1'b1;
        end
      endcase
    end

    word_tok.last_of_run = !byte_out;
    push.first  = word_out ? word_tok : byte_tok;
    push.second = byte_tok;
    push.count  = {1'b0, word_out} + {1'b0, byte_out};
    if (!fire) push.count = 2'd0;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q   <= 1'b0;
      in_word_q <= 1'b0;
      wlen_q    <= '0;
      wstart_q  <= '0;
      cand_q    <= '1;
      pos_q     <= '0;
      failed_q  <= 1'b0;
    end else begin
      stg_v_q <= stg_v_d;
      if (fire) begin
        in_word_q <= in_word_d;
        wlen_q    <= wlen_d;
        wstart_q  <= wstart_d;
        cand_q    <= cand_d;
        pos_q     <= pos_d;
        failed_q  <= failed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stg_b_q <= stg_b_d;
  end
endmodule

@@ sv/build_file_tokenizer.sv @@
// Build-file tokenizer.
// in_i  : one text byte per item, valid/ready; a zero byte ends the text.
// out_o : token items (kind, start offset, length, last_of_run), valid/ready.
//         last_of_run marks the final token caused by one input byte.
// A byte first lands in an input register; when the result queue has room, the scanner
// classifies it against the word state and pushes zero, one or two tokens
// into a 4-entry result queue that drives out_o.
// A token is offered only after its byte has passed the input register and the queue.
// Throughput: one byte per cycle while the queue has room. A byte that closes a word and
// also gives its own token pushes two items, which the output side pops one at a time.
// The scanner advances only while the queue holds at most two items, so a
// stalled receiver backs pressure up to in_i.ready with no token lost.
// After an error, bytes are consumed silently up to the end byte.
// Reset: empties the queue and input register, returns the scanner to the
// start of a text at offset 0. All reset is immediate; no clearing pass.
`include "assert_macros.svh"

module build_file_tokenizer #(
  parameter int MAX_LEXEME  = 256,
  parameter int OFFSET_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bft_byte_if.sink     in_i,
  bft_token_if.source  out_o
);
  import bft_pkg::*;

  push_t               push;
  logic                room;
  logic [LVL_BITS-1:0] level;

  // scanner with its input register
  bft_core #(
    .MAX_LEXEME (MAX_LEXEME),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .room_i(room),
    .push_o(push)
  );

  // result queue
  bft_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .level_o(level),
    .out_o  (out_o)
  );

  `ASSERT_ALWAYS(a_level_bound, clk_i, rst_ni, level <= LVL_BITS'(RES_DEPTH), "queue overflow")
  `ASSERT_IMPLY(a_push_room, clk_i, rst_ni, push.count != 2'd0, room, "push without room")
  `ASSERT_IMPLY(a_end_last, clk_i, rst_ni, out_o.valid && out_o.token_kind == KIND_END,
                out_o.last_of_run && out_o.token_length == '0, "bad end token")
  `ASSERT_IMPLY(a_pair_order, clk_i, rst_ni, push.count == 2'd2,
                !push.first.last_of_run && push.second.last_of_run, "bad pair marks")
endmodule

@@ verif/bft_token_checker.sv @@
module bft_token_checker #(
  parameter int MAX_LEXEME  = 256,
  parameter int OFFSET_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bft_byte_if   byte_ch,
  bft_token_if  tok_ch,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bft_pkg::*;

  localparam logic [31:0] POS_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

  // keyword spellings, right justified, in candidate bit order
  localparam logic [39:0] SPELLING [NUM_KW] = '{"CC", "PROJ", "LIB", "FILES", "FLAGS"};
  localparam int SPELL_LEN [NUM_KW] = '{2, 4, 3, 5, 5};

  // scanner state
  bit                in_word   = 1'b0;
  logic [7:0]        word_len  = '0;
  logic [31:0]       word_start = '0;
  logic [NUM_KW-1:0] kw_cand   = '1;
  logic [31:0]       text_pos  = '0;
  bit                failed    = 1'b0;

  token_t expected_tokens [$];
  token_t want;
  int     fails = 0;

  function automatic bit is_blank(input logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit is_word(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || b == ".";
  endfunction

  function automatic logic [7:0] spell_char(input int k, input int idx);
    if (idx >= SPELL_LEN[k]) return 8'h00;
    return SPELLING[k][8*(SPELL_LEN[k]-1-idx) +: 8];
  endfunction

  function automatic logic [NUM_KW-1:0] trim_cand(input logic [NUM_KW-1:0] cand,
                                                  input logic [7:0] idx,
                                                  input logic [7:0] b);
    logic [NUM_KW-1:0] r;
    r = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand[k] && int'(idx) < SPELL_LEN[k] && spell_char(k, int'(idx)) == b) r[k] = 1'b1;
    end
    return r;
  endfunction

  // first surviving keyword of the exact length wins
  function automatic token_kind_e word_class(input logic [NUM_KW-1:0] cand,
                                             input logic [7:0] len);
    token_kind_e kd;
    kd = KIND_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k] && int'(len) == SPELL_LEN[k]) kd = token_kind_e'(KIND_CC + 4'(k));
    end
    return kd;
  endfunction

  function automatic token_t make_tok(input token_kind_e kd, input logic [31:0] pos,
                                      input logic [7:0] len);
    token_t t;
    t.token_kind   = kd;
    t.start_offset = pos[POS_OUT_BITS-1:0];
    t.token_length = len;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  task automatic restart_text();
    in_word    = 1'b0;
    word_len   = '0;
    word_start = '0;
    kw_cand    = '1;
    text_pos   = '0;
    failed     = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    token_t      fresh [$];
    logic [31:0] pos;
    pos = text_pos & POS_MASK;
    if (failed) begin
      // dropped until the end byte
      if (b == CH_END) restart_text();
      else text_pos = (pos + 1) & POS_MASK;
    end else if (in_word && is_word(b)) begin
      if (int'(word_len) + 1 >= MAX_LEXEME) begin
        fresh   = {fresh, make_tok(KIND_ERROR, pos, 8'd1)};
        failed  = 1'b1;
        in_word = 1'b0;
      end else begin
        kw_cand  = trim_cand(kw_cand, word_len, b);
        word_len = word_len + 8'd1;
      end
      text_pos = (pos + 1) & POS_MASK;
    end else begin
      // a byte of another sort closes the word, then is handled itself
      if (in_word) begin
        fresh    = {fresh, make_tok(word_class(kw_cand, word_len), word_start, word_len)};
        in_word  = 1'b0;
        word_len = '0;
        kw_cand  = '1;
      end
      if (b == CH_END) begin
        fresh = {fresh, make_tok(KIND_END, pos, 8'd0)};
        restart_text();
      end else begin
        if (is_blank(b)) begin
        end else if (b == CH_OPEN) begin
          fresh = {fresh, make_tok(KIND_OPEN, pos, 8'd1)};
        end else if (b == CH_CLOSE) begin
          fresh = {fresh, make_tok(KIND_CLOSE, pos, 8'd1)};
        end else if (b == CH_COMMA) begin
          fresh = {fresh, make_tok(KIND_COMMA, pos, 8'd1)};
        end else if (b == CH_COLON) begin
          fresh = {fresh, make_tok(KIND_COLON, pos, 8'd1)};
        end else if (is_word(b)) begin
          in_word    = 1'b1;
          word_start = pos;
          word_len   = 8'd1;
          kw_cand    = trim_cand('1, 8'd0, b);
        end else begin
          fresh  = {fresh, make_tok(KIND_ERROR, pos, 8'd1)};
          failed = 1'b1;
        end
        text_pos = (pos + 1) & POS_MASK;
      end
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last_of_run = 1'b1;
    expected_tokens = {expected_tokens, fresh};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_text();
      expected_tokens.delete();
    end else begin
      // outputs lag inputs through the input register and the queue, so check before predicting
      if (tok_ch.valid && tok_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d offset %0d length %0d", tok_ch.token_kind,
                 tok_ch.start_offset, tok_ch.token_length);
          fails++;
        end else begin
          want = expected_tokens.pop_front();
          if (tok_ch.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind, tok_ch.token_kind);
            fails++;
          end
          if (tok_ch.start_offset !== want.start_offset) begin
            $error("start_offset: expected %0d, got %0d", want.start_offset,
                   tok_ch.start_offset);
            fails++;
          end
          if (tok_ch.token_length !== want.token_length) begin
            $error("token_length: expected %0d, got %0d", want.token_length,
                   tok_ch.token_length);
            fails++;
          end
          if (tok_ch.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   tok_ch.last_of_run);
            fails++;
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) scan_byte(byte_ch.text_byte);
    end
    pending_o    <= expected_tokens.size();
    fail_count_o <= fails;
  end

endmodule

@@ verif/tb_build_file_tokenizer.sv @@
module tb_build_file_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import bft_pkg::*;

  localparam int MAX_LEXEME  = 256;
  localparam int OFFSET_BITS = 16;
  localparam int RANDOM_ITEMS = 600;

  logic clk_i;
  logic rst_ni;
  bit   calm = 1'b0;  // both sides stop idling while set
  int   fail_count;
  int   pending;
  int   sent = 0;

  bft_byte_if  byte_ch ();
  bft_token_if tok_ch ();

  build_file_tokenizer #(
    .MAX_LEXEME (MAX_LEXEME),
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .out_o (tok_ch)
  );

  bft_token_checker #(
    .MAX_LEXEME (MAX_LEXEME),
    .OFFSET_BITS(OFFSET_BITS)
  ) token_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_ch     (byte_ch),
    .tok_ch      (tok_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop; the slowest legal run is far shorter
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // token sink: stalls about 18 percent of the time unless calm is set
  initial begin
    tok_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tok_ch.ready <= rst_ni && (calm || $urandom_range(99) >= 18);
    end
  end

  // One item on the byte channel. valid is only lowered while the sender idles,
  // never between two back-to-back items.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 18) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.text_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    string pool;
    pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.CFILPS";
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(5))
      0: return 8'd9;
      1: return 8'd10;
      2: return 8'd11;
      3: return 8'd12;
      4: return 8'd13;
      default: return CH_SPACE;
    endcase
  endfunction

  // byte that is neither blank, word, punctuation nor end
  function automatic logic [7:0] odd_byte();
    string pool;
    pool = "!\"#$%&'()*+-/;<=>?@\\^_`{|}~";
    case ($urandom_range(2))
      0: return 8'($urandom_range(128, 255));
      1: return 8'($urandom_range(1, 8));
      default: return pool[$urandom_range(pool.len() - 1)];
    endcase
  endfunction

  function automatic string keyword_text(input int k);
    case (k)
      0: return "CC";
      1: return "PROJ";
      2: return "LIB";
      3: return "FILES";
      default: return "FLAGS";
    endcase
  endfunction

  task automatic send_word(input int n);
    repeat (n) send_byte(word_char());
  endtask

  // one random lexeme or a run of blanks, optionally followed by a blank
  task automatic send_token();
    int    r;
    int    m;
    int    stop;
    string w;
    r = $urandom_range(9);
    if (r < 3) begin
      // keyword, exact or near miss: cut short, run on, or lower case
      w = keyword_text($urandom_range(4));
      m = $urandom_range(4);
      stop = (m == 2) ? w.len() - 1 : w.len();
      for (int i = 0; i < stop; i++) send_byte((m == 4 && i == 0) ? (w[i] | 8'h20) : w[i]);
      if (m == 3) send_byte(word_char());
    end else if (r < 5) begin
      send_word($urandom_range(1, 12));
    end else if (r < 8) begin
      case ($urandom_range(3))
        0: send_byte(CH_OPEN);
        1: send_byte(CH_CLOSE);
        2: send_byte(CH_COMMA);
        default: send_byte(CH_COLON);
      endcase
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(blank_char());
    end
    if ($urandom_range(1) == 1) send_byte(blank_char());
  endtask

  initial begin
    int         rand_base;
    int         pick;
    int         waited;

    rst_ni = 1'b0;
    byte_ch.valid     <= 1'b0;
    byte_ch.text_byte <= CH_END;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty text, every keyword and punctuation mark, a word
    // closed by a punctuation mark (two tokens from one byte), an unknown
    // byte inside a text with bytes dropped after it, and the top byte value
    send_byte(CH_END);
    send_str("CC:[PROJ,LIB]FILES\tFLAGS");
    send_byte(CH_END);
    send_str("A#b");
    send_byte(CH_END);
    send_byte(8'hFF);
    send_byte(CH_END);
    send_byte(CH_END);

    // random texts: mostly well formed, some noise, some broken by a bad byte
    rand_base = sent;
    while (sent - rand_base < RANDOM_ITEMS) begin
      // one long stretch with no idling on either side
      calm = (sent - rand_base >= 200) && (sent - rand_base < 450);
      pick = $urandom_range(99);
      if (pick < 75) begin
        repeat ($urandom_range(1, 10)) send_token();
        // now and then a text runs straight on into the next one
        if ($urandom_range(9) != 0) send_byte(CH_END);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
        send_byte(CH_END);
      end else begin
        repeat ($urandom_range(0, 4)) send_token();
        send_byte(odd_byte());
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(255)));
        send_byte(CH_END);
      end
    end
    calm = 1'b0;
    send_byte(CH_END);

    // longest legal word, closed by a colon and by the end byte, then a word past the length limit
    send_word(MAX_LEXEME - 1);
    send_byte(CH_COLON);
    send_byte(CH_END);
    send_word(MAX_LEXEME - 1);
    send_byte(CH_END);
    send_word(MAX_LEXEME + 20);
    send_byte(CH_COLON);
    send_byte(CH_END);
    byte_ch.valid <= 1'b0;

    // drain, then keep watching for anything stray
    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (pending != 0) $error("%0d expected tokens never arrived", pending);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
